@@ rtl/core/pbd_pkg.sv @@
// Shared types and constants for the PackBits decoder core.
// Used by the front, queue, back and top-level modules; no dependencies.
package pbd_pkg;

	localparam logic [7:0]  RUN_MARK    = 8'h80;
	localparam logic [8:0]  RUN_BASE    = 9'd257;
	localparam logic [15:0] TOTAL_RESET = 16'd1000;

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// Decoder phase, one-hot
	typedef enum logic [3:0] {
		PH_CONTROL = 4'b0001,
		PH_LITERAL = 4'b0010,
		PH_RUN     = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	// One decoded result waiting for the writer
	typedef struct packed {
		logic [7:0] value;
		logic [7:0] repeat_n;
		logic       last;
	} res_t;

	// Front-to-top handshake toward the queue
	typedef struct packed {
		logic push;
		res_t entry;
	} push_t;

endpackage

@@ rtl/core/pbd_front.sv @@
// Front end of the PackBits decoder: input transfer, stream state, run clipping.
// Depends on pbd_pkg; pushes decoded results into pbd_queue.
module pbd_front
	import pbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  logic        kind,
	input  logic [7:0]  byte_in,
	input  logic [15:0] total_bytes,
	output push_t       push_o
);

	phase_t      phase_q;
	logic [7:0]  run_left_q;
	logic [15:0] bytes_left_q;

	logic [7:0]  count_raw;
	logic [7:0]  count_clip;
	logic [7:0]  run_dec;
	logic        is_lit_ctl;

	always_comb begin
		is_lit_ctl = (byte_in < RUN_MARK);
		if (is_lit_ctl) begin
			count_raw = byte_in + 8'd1;
		end else begin
			count_raw = 8'(RUN_BASE - {1'b0, byte_in});
		end
		if ({8'd0, count_raw} > bytes_left_q) begin
			count_clip = bytes_left_q[7:0];
		end else begin
			count_clip = count_raw;
		end
		run_dec = (run_left_q != 8'd0) ? run_left_q - 8'd1 : 8'd0;
	end

	always_comb begin
		push_o                = '0;
		push_o.entry.value    = byte_in;
		push_o.entry.repeat_n = 8'd1;
		if (in_fire && kind == KIND_BYTE) begin
			unique case (phase_q)
				PH_LITERAL: begin
					push_o.push       = 1'b1;
					push_o.entry.last = (run_dec == 8'd0) && (bytes_left_q == 16'd0);
				end
				PH_RUN: begin
					push_o.push           = 1'b1;
					push_o.entry.repeat_n = run_left_q;
					push_o.entry.last     = (bytes_left_q == 16'd0);
				end
				default: begin
					push_o.push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_CONTROL;
			run_left_q   <= 8'd0;
			bytes_left_q <= TOTAL_RESET;
		end else if (in_fire) begin
			if (kind == KIND_RESTART) begin
				bytes_left_q <= total_bytes;
				run_left_q   <= 8'd0;
				phase_q      <= (total_bytes == 16'd0) ? PH_DONE : PH_CONTROL;
			end else begin
				unique case (phase_q)
					PH_CONTROL: begin
						bytes_left_q <= bytes_left_q - {8'd0, count_clip};
						run_left_q   <= count_clip;
						if (count_clip == 8'd0) begin
							phase_q <= PH_DONE;
						end else begin
							phase_q <= is_lit_ctl ? PH_LITERAL : PH_RUN;
						end
					end
					PH_LITERAL: begin
						run_left_q <= run_dec;
						if (run_dec == 8'd0) begin
							phase_q <= (bytes_left_q == 16'd0) ? PH_DONE : PH_CONTROL;
						end
					end
					PH_RUN: begin
						run_left_q <= 8'd0;
						phase_q    <= (bytes_left_q == 16'd0) ? PH_DONE : PH_CONTROL;
					end
					default: begin
						phase_q <= PH_DONE;
					end
				endcase
			end
		end
	end

endmodule

@@ rtl/core/pbd_queue.sv @@
// Short result queue between the decoder front and the output stage.
// Depends on pbd_pkg for the result entry type.
module pbd_queue
	import pbd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_entry,
	input  logic pop,
	output res_t head,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	res_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head  = slot_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/pbd_back.sv @@
// Output stage of the PackBits decoder: holds one result for the writer.
// Depends on pbd_pkg; drains pbd_queue.
module pbd_back
	import pbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  res_t       head,
	input  logic       q_empty,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_value,
	output logic [7:0] repeat_res,
	output logic       last
);

	logic out_valid_q;
	res_t out_q;
	logic load;

	assign load = !out_valid_q || !out_stall;
	assign pop  = load && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_q.value;
	assign repeat_res = out_q.repeat_n;
	assign last       = out_q.last;

endmodule

@@ rtl/core/packbits_decoder_core.sv @@
// PackBits decoder core: front decoder, result queue and output register.
// A result passes through the queue and then the output register before out_valid rises.
// Throughput: one packed byte per cycle unless stalled; control and restart bytes yield none.
// in_stall rises only while the QUEUE_DEPTH-entry result queue is full.
// Reset (arst_n low, asynchronous): expect control byte, 1000 bytes left, queue empty,
// total_bytes back to 1000.
module packbits_decoder_core
	import pbd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// packed stream input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  byte_in,
	// decoded result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_value,
	output logic [7:0]  repeat_res,
	output logic        last,
	// total_bytes register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0] total_bytes_q;
	logic        in_fire;
	push_t       push_s;
	res_t        q_head;
	logic        q_empty;
	logic        q_full;
	logic        q_pop;

	// The size register is always writable; it takes effect at the next restart.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_bytes_q <= TOTAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			total_bytes_q <= cfg_data;
		end
	end

	// Hold the input only when the queue has no room; otherwise every byte
	// transfers, whether or not it yields a result.
	assign in_stall = q_full;
	assign in_fire  = in_valid && !in_stall;

	// Front: classify control/data bytes, clip runs, track bytes left.
	pbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.kind        (kind),
		.byte_in     (byte_in),
		.total_bytes (total_bytes_q),
		.push_o      (push_s)
	);

	// Queue: decouples the front from writer back-pressure.
	pbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_s.push),
		.push_entry (push_s.entry),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	// Back: output register toward the writer; advance whenever it is free or taken.
	pbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_empty    (q_empty),
		.pop        (q_pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_value  (out_value),
		.repeat_res (repeat_res),
		.last       (last)
	);

	// A push never lands in a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_s.push |-> !q_full)
		else $error("result pushed into full queue");

	// A pop never drains an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

	// A popped entry shows up on the output in the next cycle.
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid)
		else $error("popped result not presented");

	// A literal or run result always carries a nonzero repeat.
	a_repeat_nz: assert property (@(posedge clk) disable iff (!arst_n)
		push_s.push |-> (push_s.entry.repeat_n != 8'd0))
		else $error("result with zero repeat");

endmodule
